/* design/ddw_pkg.sv */
`timescale 1ns / 1ps
// Shared widths, register codes and lane interface types for the
// date difference and weekday block. No dependencies.
package ddw_pkg;

  // Field widths
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int DN_W    = 23;  // day number since 0000-01-01, max about 5.98M
  localparam int DIFF_W  = 23;
  localparam int WD_W    = 3;

  // Number of register stages inside one lane
  localparam int LANE_STAGES = 4;

  // Configuration register indexes
  localparam logic REG_MIN_YEAR = 1'b0;
  localparam logic REG_MAX_YEAR = 1'b1;

  // Register reset values
  localparam logic [YEAR_W-1:0] MIN_YEAR_RST = 14'd1999;
  localparam logic [YEAR_W-1:0] MAX_YEAR_RST = 14'd9999;

  // Clamp for the signed difference
  localparam logic signed [DIFF_W:0] DIFF_LIMIT = 24'sd4194303;

  // Per-stage load strobes, one per lane stage
  typedef struct packed {
    logic [LANE_STAGES-1:0] load;
  } lane_ctl_t;

  // What one lane reports for its date
  typedef struct packed {
    logic [DN_W-1:0] dn;
    logic            ok;
    logic [WD_W-1:0] wd;
  } lane_res_t;

endpackage

/* design/ddw_lane.sv */
`timescale 1ns / 1ps
// One date lane: validity check, day number and weekday in four stages.
// Depends on ddw_pkg.
module ddw_lane import ddw_pkg::*; (
  input  logic               clk,
  input  lane_ctl_t          ctl,
  input  logic [YEAR_W-1:0]  year_lo,
  input  logic [YEAR_W-1:0]  year_hi,
  input  logic [YEAR_W-1:0]  year,
  input  logic [MONTH_W-1:0] month,
  input  logic [DAY_W-1:0]   day,
  output lane_res_t          res
);

  localparam logic [MONTH_W-1:0] FEB      = 4'd1;
  localparam logic [MONTH_W-1:0] DEC      = 4'd11;
  localparam logic [10:0]        RECIP_25 = 11'd1311;  // 2^15 / 25, rounded up
  localparam logic [8:0]         DAYS_YR  = 9'd365;
  // Weekday offset: epoch Sunday 2000-01-02 has day number 730487 = 2 mod 7
  localparam logic [DN_W-1:0]    WD_BIAS  = 23'd5;

  // Days before each month in a common year
  function automatic logic [8:0] cum_days(input logic [MONTH_W-1:0] m);
    logic [8:0] r;
    case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd59;
      4'd3:    r = 9'd90;
      4'd4:    r = 9'd120;
      4'd5:    r = 9'd151;
      4'd6:    r = 9'd181;
      4'd7:    r = 9'd212;
      4'd8:    r = 9'd243;
      4'd9:    r = 9'd273;
      4'd10:   r = 9'd304;
      4'd11:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Month length in a common year
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] r;
    case (m)
      4'd1:                    r = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: r = 5'd30;
      default:                 r = 5'd31;
    endcase
    return r;
  endfunction

  // Residue mod 7 by folding octal digits (8 = 1 mod 7)
  function automatic logic [WD_W-1:0] mod7(input logic [DN_W-1:0] v);
    logic [DN_W:0] x;
    logic [5:0]    s1;
    logic [3:0]    s2;
    logic [2:0]    s3;
    x  = {1'b0, v};
    s1 = '0;
    for (int i = 0; i < (DN_W + 1) / 3; i++) begin
      s1 = s1 + 6'(x[3*i +: 3]);
    end
    s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
    s3 = 3'(s2[3]) + s2[2:0];
    return (s3 == 3'd7) ? 3'd0 : s3;
  endfunction

  // ---------------- stage 1: constant divisions and range checks
  logic [YEAR_W:0]   v100, v400, v4;
  logic [23:0]       p100;
  logic [21:0]       p400;

  logic [YEAR_W-1:0]  s1_year;
  logic [MONTH_W-1:0] s1_month;
  logic [DAY_W-1:0]   s1_day;
  logic [DN_W-1:0]    s1_y365;
  logic [12:0]        s1_q4;
  logic [7:0]         s1_q100;
  logic [5:0]         s1_q400;
  logic               s1_y4, s1_yr_ok, s1_mon_ok;

  // ceil(y/100) = floor((y+99)/4/25), ceil(y/400) = floor((y+399)/16/25)
  always_comb begin
    v100 = 15'(year) + 15'd99;
    v400 = 15'(year) + 15'd399;
    v4   = 15'(year) + 15'd3;
    p100 = 24'(v100[YEAR_W:2]) * 24'(RECIP_25);
    p400 = 22'(v400[YEAR_W:4]) * 22'(RECIP_25);
  end

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      s1_year   <= year;
      s1_month  <= month;
      s1_day    <= day;
      s1_y365   <= DN_W'(year) * DN_W'(DAYS_YR);
      s1_q4     <= v4[YEAR_W:2];
      s1_q100   <= p100[22:15];
      s1_q400   <= p400[20:15];
      s1_y4     <= (year[1:0] == 2'd0);
      s1_yr_ok  <= (year >= year_lo) && (year <= year_hi);
      s1_mon_ok <= (month <= DEC);
    end
  end

  // ---------------- stage 2: leap year and year base
  logic               c100, c400;
  logic [MONTH_W-1:0] s2_month;
  logic [DAY_W-1:0]   s2_day;
  logic [DN_W-1:0]    s2_base;
  logic               s2_leap, s2_yr_ok, s2_mon_ok;

  always_comb begin
    c100 = ((15'(s1_q100) * 15'd100) == 15'(s1_year));
    c400 = ((15'(s1_q400) * 15'd400) == 15'(s1_year));
  end

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      s2_month  <= s1_month;
      s2_day    <= s1_day;
      s2_base   <= s1_y365 + DN_W'(s1_q4) + DN_W'(s1_q400) - DN_W'(s1_q100);
      s2_leap   <= s1_y4 && (!c100 || c400);
      s2_yr_ok  <= s1_yr_ok;
      s2_mon_ok <= s1_mon_ok;
    end
  end

  // ---------------- stage 3: day check and day number
  logic [MONTH_W-1:0] msel;
  logic [DAY_W-1:0]   mlen;
  logic               day_ok;
  logic [DN_W-1:0]    s3_dn;
  logic               s3_ok;

  always_comb begin
    msel   = s2_mon_ok ? s2_month : '0;
    mlen   = month_days(msel) + DAY_W'(msel == FEB && s2_leap);
    day_ok = (s2_day != '0) && (s2_day <= mlen);
  end

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      s3_dn <= s2_base + DN_W'(cum_days(msel)) + DN_W'(msel > FEB && s2_leap)
               + DN_W'(s2_day);
      s3_ok <= s2_yr_ok && s2_mon_ok && day_ok;
    end
  end

  // ---------------- stage 4: weekday
  always_ff @(posedge clk) begin
    if (ctl.load[3]) begin
      res.dn <= s3_dn;
      res.ok <= s3_ok;
      res.wd <= mod7(s3_dn + WD_BIAS);
    end
  end

endmodule

/* design/ddw_merge.sv */
`timescale 1ns / 1ps
// Merge stage: signed difference of the two lane day numbers, clamp,
// gating by validity, and the output register. Depends on ddw_pkg.
module ddw_merge import ddw_pkg::*; (
  input  logic                     clk,
  input  logic                     load,
  input  lane_res_t                first_res,
  input  lane_res_t                second_res,
  output logic signed [DIFF_W-1:0] day_difference,
  output logic                     first_ok,
  output logic                     second_ok,
  output logic [WD_W-1:0]          first_weekday,
  output logic [WD_W-1:0]          second_weekday
);

  logic signed [DN_W:0]     diff_full;
  logic signed [DIFF_W-1:0] diff_sat;
  logic                     both_ok;

  // Subtract and clamp to the symmetric limit
  always_comb begin
    both_ok   = first_res.ok && second_res.ok;
    diff_full = $signed({1'b0, second_res.dn}) - $signed({1'b0, first_res.dn});
    if (diff_full > DIFF_LIMIT) begin
      diff_sat = DIFF_W'(DIFF_LIMIT);
    end else if (diff_full < -DIFF_LIMIT) begin
      diff_sat = DIFF_W'(-DIFF_LIMIT);
    end else begin
      diff_sat = diff_full[DIFF_W-1:0];
    end
  end

  // Hold the result beat until the consumer takes it
  always_ff @(posedge clk) begin
    if (load) begin
      day_difference <= both_ok ? diff_sat : '0;
      first_ok       <= first_res.ok;
      second_ok      <= second_res.ok;
      first_weekday  <= both_ok ? first_res.wd : '0;
      second_weekday <= both_ok ? second_res.wd : '0;
    end
  end

endmodule

/* design/date_difference_and_weekday.sv */
`timescale 1ns / 1ps
// Gregorian day difference and weekday of two dates, one lane per date.
// Each beat passes through the four lane stages and then the merge
// register. Throughput: one beat per cycle while not stalled; the pipeline
// holds five beats and each stage advances whenever the stage after it frees up.
// Reset clears all stage valid bits and sets the year bounds to 1999 and 9999.
module date_difference_and_weekday import ddw_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  // configuration
  input  logic                     cfg_wen,
  input  logic                     cfg_index,
  input  logic [YEAR_W-1:0]        cfg_data,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [YEAR_W-1:0]        first_year,
  input  logic [MONTH_W-1:0]       first_month,
  input  logic [DAY_W-1:0]         first_day,
  input  logic [YEAR_W-1:0]        second_year,
  input  logic [MONTH_W-1:0]       second_month,
  input  logic [DAY_W-1:0]         second_day,
  // output channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DIFF_W-1:0] day_difference,
  output logic                     first_ok,
  output logic                     second_ok,
  output logic [WD_W-1:0]          first_weekday,
  output logic [WD_W-1:0]          second_weekday
);

  logic [YEAR_W-1:0]      year_lo, year_hi;
  logic [LANE_STAGES-1:0] stage_valid;
  logic [LANE_STAGES:0]   rdy;
  lane_ctl_t              ctl;
  lane_res_t              first_res, second_res;

  // Year bound registers
  always_ff @(posedge clk) begin
    if (rst) begin
      year_lo <= MIN_YEAR_RST;
      year_hi <= MAX_YEAR_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_MIN_YEAR: year_lo <= cfg_data;
        REG_MAX_YEAR: year_hi <= cfg_data;
        default:      ;
      endcase
    end
  end

  // Stage ready chain: a stage may load when empty or when it drains
  always_comb begin
    rdy[LANE_STAGES] = !out_valid || !out_stall;
    for (int k = LANE_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !stage_valid[k] || rdy[k+1];
    end
    ctl.load = rdy[LANE_STAGES-1:0];
    in_stall = !rdy[0];
  end

  // Advance valid bits along the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (rdy[0]) begin
        stage_valid[0] <= in_valid;
      end
      for (int k = 1; k < LANE_STAGES; k++) begin
        if (rdy[k]) begin
          stage_valid[k] <= stage_valid[k-1];
        end
      end
      if (rdy[LANE_STAGES]) begin
        out_valid <= stage_valid[LANE_STAGES-1];
      end
    end
  end

  ddw_lane u_first_lane (
    .clk     (clk),
    .ctl     (ctl),
    .year_lo (year_lo),
    .year_hi (year_hi),
    .year    (first_year),
    .month   (first_month),
    .day     (first_day),
    .res     (first_res)
  );

  ddw_lane u_second_lane (
    .clk     (clk),
    .ctl     (ctl),
    .year_lo (year_lo),
    .year_hi (year_hi),
    .year    (second_year),
    .month   (second_month),
    .day     (second_day),
    .res     (second_res)
  );

  ddw_merge u_merge (
    .clk            (clk),
    .load           (rdy[LANE_STAGES]),
    .first_res      (first_res),
    .second_res     (second_res),
    .day_difference (day_difference),
    .first_ok       (first_ok),
    .second_ok      (second_ok),
    .first_weekday  (first_weekday),
    .second_weekday (second_weekday)
  );

  // An invalid date zeroes the difference and both weekdays
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !(first_ok && second_ok) |->
      day_difference == '0 && first_weekday == '0 && second_weekday == '0)
    else $error("invalid date produced nonzero result");

  // Weekdays stay in 0..6
  a_weekday_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> first_weekday != 3'd7 && second_weekday != 3'd7)
    else $error("weekday out of range");

  // The clamp never lets the most negative code through
  a_diff_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> day_difference != $signed({1'b1, {(DIFF_W-1){1'b0}}}))
    else $error("difference outside clamp");

  // Input stalls only when the first stage holds a beat that cannot move
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> stage_valid[0] && out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

endmodule
